FILE: design/bcp_pkg.sv
`default_nettype none
package bcp_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int POS_K = 928;
	localparam int CORDIC_STEPS = 15;
	localparam int QUOT_BITS = 18;
	localparam int OUT_BITS = 16;
	localparam int N_PAIRS = 6;

	localparam logic CFG_CAL_X = 1'b0;
	localparam logic CFG_CAL_Y = 1'b1;

	typedef logic [2:0] pair_idx_t;
	typedef logic [1:0] blob_idx_t;

	// first end of each blob pair, in the order 01,02,03,12,13,23
	function automatic blob_idx_t pair_lo(input pair_idx_t i);
		blob_idx_t r;
		case (i)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic blob_idx_t pair_hi(input pair_idx_t i);
		blob_idx_t r;
		case (i)
			3'd0:       r = 2'd1;
			3'd1, 3'd3: r = 2'd2;
			default:    r = 2'd3;
		endcase
		return r;
	endfunction

	// rounded arctangent of 2^-i, units of pi/32768
	function automatic logic [15:0] atan_val(input int i);
		logic [15:0] r;
		case (i)
			0:       r = 16'd8192;
			1:       r = 16'd4836;
			2:       r = 16'd2555;
			3:       r = 16'd1297;
			4:       r = 16'd651;
			5:       r = 16'd326;
			6:       r = 16'd163;
			7:       r = 16'd81;
			8:       r = 16'd41;
			9:       r = 16'd20;
			10:      r = 16'd10;
			11:      r = 16'd5;
			12:      r = 16'd3;
			13:      r = 16'd1;
			14:      r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/beacon_constellation_pose.sv
// Pipeline from input accept to result valid: 18 quotient stages plus 8 other stages.
// Throughput: one item per cycle; a held result stalls the whole pipeline, nothing is
// dropped. The position dividers (one quotient bit per stage) set the depth.
// Reset: arst_n clears every stage valid bit and both calibration registers;
// data registers are not reset.
`default_nettype none
module beacon_constellation_pose #(
	parameter int COORD_BITS = bcp_pkg::COORD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// x0, y0, x1, y1, x2, y2, x3, y3
	input  wire logic [8*COORD_BITS-1:0] s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// valid_res, pos_x, pos_y, heading, zero pad
	output logic [55:0]                  m_tdata,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_idx,
	input  wire logic [15:0]             cfg_data
);
	import bcp_pkg::*;

	localparam int N = COORD_BITS;
	localparam int QB = QUOT_BITS;
	localparam int MW = 2 * N + 1;
	localparam int AW = 2 * N + 16;
	localparam int BW = 2 * N + 2;
	localparam int LAT = 8 + QB;
	localparam int ZDLY = 4 + QB - (1 + CORDIC_STEPS);

	logic en;
	logic [LAT:1] vld_q;
	logic signed [15:0] cal_x_q, cal_y_q;

	assign en = m_tready | ~vld_q[LAT];
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], s_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_x_q <= '0;
			cal_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CAL_X: cal_x_q <= cfg_data;
				CFG_CAL_Y: cal_y_q <= cfg_data;
			endcase
		end
	end

	logic ok_s3;
	logic signed [N:0] dx_s3, dy_s3;
	logic signed [N+1:0] u_s3, v_s3;
	logic [MW-1:0] mx_s3;

	bcp_geom #(.COORD_BITS(N)) u_geom (
		.clk(clk), .en(en), .tdata(s_tdata),
		.ok_s3(ok_s3), .dx_s3(dx_s3), .dy_s3(dy_s3),
		.u_s3(u_s3), .v_s3(v_s3), .mx_s3(mx_s3)
	);

	logic [15:0] angle;

	bcp_cordic #(.COORD_BITS(N)) u_cordic (
		.clk(clk), .en(en), .dx(dx_s3), .dy(dy_s3), .angle(angle)
	);

	// cross and dot products of the north-south vector with the centre offset
	logic signed [2*N+2:0] dxv_s4, dyu_s4, dxu_s4, dyv_s4;
	logic signed [2*N+3:0] nx_s5, ny_s5;
	logic signed [2*N+14:0] kx_s6, ky_s6;
	logic [AW-1:0] ax_s7, ay_s7;
	logic [BW-1:0] b_s7;
	logic [MW-1:0] mx_s4, mx_s5, mx_s6;
	logic ok_s4, ok_s5, ok_s6, ok_s7;
	logic sx_s7, sy_s7;

	always_ff @(posedge clk) begin
		logic [2*N+14:0] magx, magy;
		if (en) begin
			dxv_s4 <= dx_s3 * v_s3;
			dyu_s4 <= dy_s3 * u_s3;
			dxu_s4 <= dx_s3 * u_s3;
			dyv_s4 <= dy_s3 * v_s3;
			mx_s4 <= mx_s3;
			ok_s4 <= ok_s3;

			nx_s5 <= (2*N+4)'(dxv_s4) - (2*N+4)'(dyu_s4);
			ny_s5 <= (2*N+4)'(dxu_s4) + (2*N+4)'(dyv_s4);
			mx_s5 <= mx_s4;
			ok_s5 <= ok_s4;

			kx_s6 <= (2*N+15)'(nx_s5) * (2*N+15)'(POS_K);
			ky_s6 <= (2*N+15)'(ny_s5) * (2*N+15)'(POS_K);
			mx_s6 <= mx_s5;
			ok_s6 <= ok_s5;

			// round half away from zero: (2|n| + m) / 2m
			magx = kx_s6[2*N+14] ? $unsigned(-kx_s6) : $unsigned(kx_s6);
			magy = ky_s6[2*N+14] ? $unsigned(-ky_s6) : $unsigned(ky_s6);
			ax_s7 <= AW'({magx, 1'b0}) + AW'(mx_s6);
			ay_s7 <= AW'({magy, 1'b0}) + AW'(mx_s6);
			b_s7 <= {mx_s6, 1'b0};
			sx_s7 <= kx_s6[2*N+14];
			sy_s7 <= ky_s6[2*N+14];
			ok_s7 <= ok_s6;
		end
	end

	logic [QB-1:0] qx, qy;
	logic ovx, ovy;

	bcp_div #(.AW(AW), .BW(BW), .QB(QB)) u_div_x (
		.clk(clk), .en(en), .num(ax_s7), .den(b_s7), .quot(qx), .ovf(ovx)
	);

	bcp_div #(.AW(AW), .BW(BW), .QB(QB)) u_div_y (
		.clk(clk), .en(en), .num(ay_s7), .den(b_s7), .quot(qy), .ovf(ovy)
	);

	// side data held level with the dividers and the angle
	logic ok_d [QB];
	logic sx_d [QB];
	logic sy_d [QB];
	logic [15:0] z_d [ZDLY];

	always_ff @(posedge clk) begin
		if (en) begin
			ok_d[0] <= ok_s7;
			sx_d[0] <= sx_s7;
			sy_d[0] <= sy_s7;
			for (int k = 1; k < QB; k++) begin
				ok_d[k] <= ok_d[k-1];
				sx_d[k] <= sx_d[k-1];
				sy_d[k] <= sy_d[k-1];
			end
			z_d[0] <= angle;
			for (int k = 1; k < ZDLY; k++)
				z_d[k] <= z_d[k-1];
		end
	end

	function automatic logic [15:0] sat16(input logic signed [QB+3:0] v);
		logic [15:0] r;
		if (v > (QB+4)'(32767))
			r = 16'h7FFF;
		else if (v < -(QB+4)'(32768))
			r = 16'h8000;
		else
			r = v[15:0];
		return r;
	endfunction

	logic [55:0] res_c;

	always_comb begin
		logic [QB-1:0] mqx, mqy;
		logic signed [QB+3:0] vx, vy;
		mqx = ovx ? '1 : qx;
		mqy = ovy ? '1 : qy;
		vx = sx_d[QB-1] ? -$signed((QB+4)'(mqx)) : $signed((QB+4)'(mqx));
		vy = sy_d[QB-1] ? -$signed((QB+4)'(mqy)) : $signed((QB+4)'(mqy));
		vx = vx - (QB+4)'(cal_x_q);
		vy = vy + (QB+4)'(POS_K) - (QB+4)'(cal_y_q);
		if (ok_d[QB-1])
			res_c = {7'd0, z_d[ZDLY-1] + 16'h4000, sat16(vy), sat16(vx), 1'b1};
		else
			res_c = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res_c;
		end
	end

endmodule
`default_nettype wire

FILE: design/bcp_geom.sv
`default_nettype none
module bcp_geom #(
	parameter int COORD_BITS = bcp_pkg::COORD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [8*COORD_BITS-1:0]   tdata,
	output logic                           ok_s3,
	output logic signed [COORD_BITS:0]     dx_s3,
	output logic signed [COORD_BITS:0]     dy_s3,
	output logic signed [COORD_BITS+1:0]   u_s3,
	output logic signed [COORD_BITS+1:0]   v_s3,
	output logic [2*COORD_BITS:0]          mx_s3
);
	import bcp_pkg::*;

	localparam int N = COORD_BITS;
	localparam int D2W = 2 * N + 1;
	localparam logic [N-1:0] MISSING = {N{1'b1}};
	localparam logic signed [N+1:0] CX2 = (N + 2)'((1 << N) - 1);
	localparam logic signed [N+1:0] CY2 = (N + 2)'(3 * (1 << (N - 2)) - 1);

	logic [N-1:0] px_in [4];
	logic [N-1:0] py_in [4];
	logic [D2W-1:0] d2_in [N_PAIRS];
	logic miss_in;

	logic [N-1:0] px_s1 [4];
	logic [N-1:0] py_s1 [4];
	logic [D2W-1:0] d2_s1 [N_PAIRS];
	logic miss_s1;

	logic [N-1:0] px_s2 [4];
	logic [N-1:0] py_s2 [4];
	logic [D2W-1:0] mx_s2;
	pair_idx_t imax_s2, imin_s2;
	logic miss_s2;

	logic [D2W-1:0] mx_c, mn_c;
	pair_idx_t imax_c, imin_c;

	logic ok_c;
	logic signed [N:0] dx_c, dy_c;
	logic signed [N+1:0] u_c, v_c;

	always_comb begin
		logic signed [N:0] ex, ey;
		logic signed [2*N+1:0] sq;
		miss_in = 1'b0;
		for (int i = 0; i < 4; i++) begin
			px_in[i] = tdata[2*i*N +: N];
			py_in[i] = tdata[(2*i+1)*N +: N];
			if (py_in[i] == MISSING)
				miss_in = 1'b1;
		end
		for (int p = 0; p < N_PAIRS; p++) begin
			ex = $signed({1'b0, px_in[pair_hi(3'(p))]}) - $signed({1'b0, px_in[pair_lo(3'(p))]});
			ey = $signed({1'b0, py_in[pair_hi(3'(p))]}) - $signed({1'b0, py_in[pair_lo(3'(p))]});
			sq = ex * ex + ey * ey;
			d2_in[p] = D2W'($unsigned(sq));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px_in;
			py_s1 <= py_in;
			d2_s1 <= d2_in;
			miss_s1 <= miss_in;
		end
	end

	// longest and shortest pair; later pair wins a tie
	always_comb begin
		mx_c = d2_s1[0];
		mn_c = d2_s1[0];
		imax_c = '0;
		imin_c = '0;
		for (int p = 0; p < N_PAIRS; p++) begin
			if (d2_s1[p] >= mx_c) begin
				mx_c = d2_s1[p];
				imax_c = 3'(p);
			end
			if (d2_s1[p] <= mn_c) begin
				mn_c = d2_s1[p];
				imin_c = 3'(p);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			mx_s2 <= mx_c;
			imax_s2 <= imax_c;
			imin_s2 <= imin_c;
			miss_s2 <= miss_s1;
		end
	end

	always_comb begin
		blob_idx_t ends_max [2];
		blob_idx_t ends_min [2];
		blob_idx_t north, south;
		logic found;
		ends_max[0] = pair_lo(imax_s2);
		ends_max[1] = pair_hi(imax_s2);
		ends_min[0] = pair_lo(imin_s2);
		ends_min[1] = pair_hi(imin_s2);
		north = '0;
		found = 1'b0;
		for (int a = 0; a < 2; a++)
			for (int b = 0; b < 2; b++)
				if (ends_max[a] == ends_min[b]) begin
					north = ends_max[a];
					found = 1'b1;
				end
		south = (ends_max[0] == north) ? ends_max[1] : ends_max[0];
		ok_c = found && !miss_s2 && (mx_s2 != '0);
		dx_c = $signed({1'b0, px_s2[north]}) - $signed({1'b0, px_s2[south]});
		dy_c = $signed({1'b0, py_s2[north]}) - $signed({1'b0, py_s2[south]});
		u_c = CX2 - $signed({1'b0, px_s2[north], 1'b0});
		v_c = CY2 - $signed({1'b0, py_s2[north], 1'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3 <= ok_c;
			dx_s3 <= dx_c;
			dy_s3 <= dy_c;
			u_s3 <= u_c;
			v_s3 <= v_c;
			mx_s3 <= mx_s2;
		end
	end

endmodule
`default_nettype wire

FILE: design/bcp_cordic.sv
`default_nettype none
module bcp_cordic #(
	parameter int COORD_BITS = bcp_pkg::COORD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [COORD_BITS:0] dx,
	input  wire logic signed [COORD_BITS:0] dy,
	output logic [15:0]                    angle
);
	import bcp_pkg::*;

	localparam int CW = COORD_BITS + 20;

	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic [15:0] z_s [CORDIC_STEPS+1];

	logic signed [CW-1:0] x0, y0;

	assign x0 = CW'(dx) <<< 16;
	assign y0 = CW'(dy) <<< 16;

	// fold the left half plane over first
	always_ff @(posedge clk) begin
		if (en) begin
			if (x0 < 0) begin
				x_s[0] <= -x0;
				y_s[0] <= -y0;
				z_s[0] <= 16'h8000;
			end else begin
				x_s[0] <= x0;
				y_s[0] <= y0;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_val(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_val(i);
				end
			end
		end
	end

	assign angle = z_s[CORDIC_STEPS];

endmodule
`default_nettype wire

FILE: design/bcp_div.sv
`default_nettype none
module bcp_div #(
	parameter int AW = 36,
	parameter int BW = 22,
	parameter int QB = bcp_pkg::QUOT_BITS
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] num,
	input  wire logic [BW-1:0] den,
	output logic [QB-1:0]      quot,
	output logic               ovf
);
	localparam int RW = (AW > BW + QB) ? AW : BW + QB;

	logic [RW-1:0] r_s [QB+1];
	logic [BW-1:0] b_s [QB+1];
	logic [QB-1:0] q_s [QB+1];
	logic          o_s [QB+1];

	assign r_s[0] = RW'(num);
	assign b_s[0] = den;
	assign q_s[0] = '0;
	assign o_s[0] = (RW'(num) >= (RW'(den) << QB));

	// one quotient bit per stage, top bit first
	for (genvar k = 0; k < QB; k++) begin : g_bit
		logic [RW-1:0] sh;
		assign sh = RW'(b_s[k]) << (QB - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				b_s[k+1] <= b_s[k];
				o_s[k+1] <= o_s[k];
				if (r_s[k] >= sh) begin
					r_s[k+1] <= r_s[k] - sh;
					q_s[k+1] <= q_s[k] | (QB'(1) << (QB - 1 - k));
				end else begin
					r_s[k+1] <= r_s[k];
					q_s[k+1] <= q_s[k];
				end
			end
		end
	end

	assign quot = q_s[QB];
	assign ovf = o_s[QB];

endmodule
`default_nettype wire
